@@ rtl/pfa_pkg.sv @@
// shared types, constants and codes of the penalty force accumulator
package pfa_pkg;

    localparam int MAX_POINTS_DEFAULT = 4096;
    localparam int HIT_FIELD_MAX      = 8191;
    localparam int HIT_W              = 13;
    localparam int ONE_Q14            = 16384;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [15:0] VOXEL_SIZE_RESET  = 16'd256;
    localparam logic [15:0] STIFFNESS_RESET   = 16'd256;
    localparam logic [15:0] SCALE_MAT0_RESET  = 16'd16384;
    localparam logic [15:0] SCALE_MAT1_RESET  = 16'd9830;
    localparam logic [15:0] SCALE_MAT2_RESET  = 16'd3277;
    localparam logic [15:0] SCALE_MAT3_RESET  = 16'd13107;

    typedef enum logic [2:0] {
        CFG_VOXEL_SIZE  = 3'd0,
        CFG_BASE_STIFF  = 3'd1,
        CFG_SCALE_MAT0  = 3'd2,
        CFG_SCALE_MAT1  = 3'd3,
        CFG_SCALE_MAT2  = 3'd4,
        CFG_SCALE_MAT3  = 3'd5
    } pfa_cfg_idx_t;

    typedef enum logic [7:0] {
        MAT_ZERO  = 8'd0,
        MAT_ONE   = 8'd1,
        MAT_TWO   = 8'd2,
        MAT_THREE = 8'd3
    } pfa_material_t;

    typedef struct packed {
        logic               hit;
        logic               last;
        logic signed [15:0] arm_x;
        logic signed [15:0] arm_y;
        logic signed [15:0] arm_z;
        logic signed [16:0] g_x;
        logic signed [16:0] g_y;
        logic signed [16:0] g_z;
        logic [30:0]        depth;
        logic [15:0]        scale;
    } pfa_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAG1,
        ST_MAG2,
        ST_SQ,
        ST_SQRT,
        ST_DINIT,
        ST_DIV,
        ST_FMUL,
        ST_TQA,
        ST_TQB,
        ST_ACC,
        ST_LAST
    } pfa_back_state_t;

endpackage

@@ rtl/pfa_if.sv @@
// handshake channels of the penalty force accumulator
interface pfa_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] arm_x;
    logic signed [15:0] arm_y;
    logic signed [15:0] arm_z;
    logic signed [15:0] dist_centre;
    logic signed [15:0] dist_x_plus;
    logic signed [15:0] dist_x_minus;
    logic signed [15:0] dist_y_plus;
    logic signed [15:0] dist_y_minus;
    logic signed [15:0] dist_z_plus;
    logic signed [15:0] dist_z_minus;
    logic [7:0]         material_code;
    logic               last_point;

    modport source (
        output valid, arm_x, arm_y, arm_z, dist_centre, dist_x_plus, dist_x_minus,
               dist_y_plus, dist_y_minus, dist_z_plus, dist_z_minus, material_code,
               last_point,
        input  ready
    );
    modport sink (
        input  valid, arm_x, arm_y, arm_z, dist_centre, dist_x_plus, dist_x_minus,
               dist_y_plus, dist_y_minus, dist_z_plus, dist_z_minus, material_code,
               last_point,
        output ready
    );
endinterface

interface pfa_totals_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] torque_x;
    logic signed [31:0] torque_y;
    logic signed [31:0] torque_z;
    logic [12:0]        hit_count;
    logic               any_hit;

    modport source (
        output valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
               hit_count, any_hit,
        input  ready
    );
    modport sink (
        input  valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
               hit_count, any_hit,
        output ready
    );
endinterface

interface pfa_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/pfa_front.sv @@
// front end: configuration registers, hit classification, gradient and depth
module pfa_front (
    input  logic              clk,
    input  logic              rst_n,
    pfa_sample_if.sink        sample,
    pfa_cfg_if.sink           cfg,
    input  logic              q_full,
    output logic              q_push,
    output pfa_pkg::pfa_item_t q_item,
    output logic [15:0]       base_stiffness
);
    import pfa_pkg::*;

    logic [15:0] voxel_reg;
    logic [15:0] stiff_reg;
    logic [15:0] scale0_reg;
    logic [15:0] scale1_reg;
    logic [15:0] scale2_reg;
    logic [15:0] scale3_reg;

    logic signed [16:0] neg_dc;
    logic [31:0]        depth_full;
    logic [15:0]        scale_pick;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voxel_reg  <= VOXEL_SIZE_RESET;
            stiff_reg  <= STIFFNESS_RESET;
            scale0_reg <= SCALE_MAT0_RESET;
            scale1_reg <= SCALE_MAT1_RESET;
            scale2_reg <= SCALE_MAT2_RESET;
            scale3_reg <= SCALE_MAT3_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_VOXEL_SIZE: voxel_reg  <= cfg.data;
                CFG_BASE_STIFF: stiff_reg  <= cfg.data;
                CFG_SCALE_MAT0: scale0_reg <= cfg.data;
                CFG_SCALE_MAT1: scale1_reg <= cfg.data;
                CFG_SCALE_MAT2: scale2_reg <= cfg.data;
                CFG_SCALE_MAT3: scale3_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign cfg.ready      = 1'b1;
    assign base_stiffness = stiff_reg;

    assign sample.ready = !q_full;
    assign q_push       = sample.valid && !q_full;

    always_comb
    begin
        neg_dc     = -17'(sample.dist_centre);
        depth_full = 32'(neg_dc[15:0]) * 32'(voxel_reg);
        unique case (sample.material_code)
            MAT_ZERO:  scale_pick = scale0_reg;
            MAT_ONE:   scale_pick = scale1_reg;
            MAT_TWO:   scale_pick = scale2_reg;
            MAT_THREE: scale_pick = scale3_reg;
            default:   scale_pick = 16'(ONE_Q14);
        endcase
        if (scale_pick == 16'd0)
        begin
            scale_pick = 16'(ONE_Q14);
        end

        q_item.hit   = sample.dist_centre[15];
        q_item.last  = sample.last_point;
        q_item.arm_x = sample.arm_x;
        q_item.arm_y = sample.arm_y;
        q_item.arm_z = sample.arm_z;
        q_item.g_x   = 17'(sample.dist_x_plus) - 17'(sample.dist_x_minus);
        q_item.g_y   = 17'(sample.dist_y_plus) - 17'(sample.dist_y_minus);
        q_item.g_z   = 17'(sample.dist_z_plus) - 17'(sample.dist_z_minus);
        q_item.depth = depth_full[30:0];
        q_item.scale = scale_pick;
    end

endmodule

@@ rtl/pfa_queue.sv @@
// short word queue between front and back end
module pfa_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  pfa_pkg::pfa_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               nonempty,
    output pfa_pkg::pfa_item_t head
);
    import pfa_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    pfa_item_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/pfa_back.sv @@
// back end: magnitude, normalisation, torque, saturating sums and result word
module pfa_back #(
    parameter int MAX_POINTS = pfa_pkg::MAX_POINTS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  pfa_pkg::pfa_item_t q_item,
    output logic               q_pop,
    input  logic [15:0]        base_stiffness,
    pfa_totals_if.source       totals
);
    import pfa_pkg::*;

    localparam int HIT_CAP = (MAX_POINTS > HIT_FIELD_MAX) ? HIT_FIELD_MAX : MAX_POINTS;
    localparam logic [HIT_W-1:0] HIT_CAP_V = HIT_W'(HIT_CAP);

    function automatic logic signed [47:0] sat_add(input logic signed [47:0] a,
                                                   input logic signed [42:0] b);
        logic signed [48:0] s;
        s = 49'(a) + 49'(b);
        if (s[48] != s[47])
        begin
            return s[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
        end
        return s[47:0];
    endfunction

    function automatic logic signed [42:0] trunc_shr8(input logic signed [50:0] v);
        logic signed [50:0] r;
        r = v + (v[50] ? 51'sd255 : 51'sd0);
        return r[50:8];
    endfunction

    function automatic logic [31:0] sat32(input logic signed [47:0] v);
        if ((&v[47:31]) || !(|v[47:31]))
        begin
            return v[31:0];
        end
        return v[47] ? 32'h8000_0000 : 32'h7fff_ffff;
    endfunction

    pfa_back_state_t    state_reg, state_next;
    logic [1:0]         idx_reg, idx_next;
    logic [3:0]         cnt_reg;
    pfa_item_t          item_reg;
    logic [46:0]        prod_reg;
    logic [32:0]        mag_reg;
    logic [33:0]        ssq_reg;
    logic [61:0]        rad_reg;
    logic [61:0]        root_reg;
    logic [61:0]        bit_reg;
    logic [30:0]        len_reg;
    logic [44:0]        rem_reg;
    logic [44:0]        dsr_reg;
    logic [14:0]        quo_reg;
    logic signed [33:0] fx_reg, fy_reg, fz_reg;
    logic signed [49:0] prt_reg;
    logic signed [50:0] tx_reg, ty_reg, tz_reg;
    logic signed [47:0] fsum_x_reg, fsum_y_reg, fsum_z_reg;
    logic signed [47:0] tsum_x_reg, tsum_y_reg, tsum_z_reg;
    logic [HIT_W-1:0]   hits_reg;
    logic               out_valid_reg;
    logic [31:0]        force_x_reg, force_y_reg, force_z_reg;
    logic [31:0]        torque_x_reg, torque_y_reg, torque_z_reg;
    logic [HIT_W-1:0]   hit_count_reg;
    logic               any_hit_reg;

    logic               out_free;
    logic               out_load;
    logic [62:0]        mag_full;
    logic signed [16:0] g_sel;
    logic signed [33:0] g_sq;
    logic [33:0]        ssq_sum;
    logic [15:0]        g_mag;
    logic [61:0]        trial;
    logic               sq_take;
    logic [61:0]        root_new;
    logic               div_take;
    logic [14:0]        un_c;
    logic [47:0]        fprod;
    logic signed [33:0] fval;
    logic signed [15:0] ma;
    logic signed [33:0] mb;
    logic signed [49:0] tprod;
    logic signed [50:0] tdiff;

    assign out_free = !out_valid_reg || totals.ready;

    always_comb
    begin
        mag_full = 63'(prod_reg) * 63'(item_reg.scale);
        case (idx_reg)
            2'd0:    g_sel = item_reg.g_x;
            2'd1:    g_sel = item_reg.g_y;
            default: g_sel = item_reg.g_z;
        endcase
        g_sq     = g_sel * g_sel;
        ssq_sum  = ssq_reg + 34'(g_sq[31:0]);
        g_mag    = g_sel[16] ? 16'(-g_sel) : 16'(g_sel);
        trial    = root_reg + bit_reg;
        sq_take  = (rad_reg >= trial);
        root_new = sq_take ? ((root_reg >> 1) + bit_reg) : (root_reg >> 1);
        div_take = (rem_reg >= dsr_reg);
        un_c     = (quo_reg > 15'(ONE_Q14)) ? 15'(ONE_Q14) : quo_reg;
        fprod    = 48'(mag_reg) * 48'(un_c);
        fval     = g_sel[16] ? -$signed({1'b0, fprod[46:14]}) : $signed({1'b0, fprod[46:14]});
        if (state_reg == ST_TQA)
        begin
            case (idx_reg)
                2'd0:    begin ma = item_reg.arm_y; mb = fz_reg; end
                2'd1:    begin ma = item_reg.arm_z; mb = fx_reg; end
                default: begin ma = item_reg.arm_x; mb = fy_reg; end
            endcase
        end
        else
        begin
            case (idx_reg)
                2'd0:    begin ma = item_reg.arm_z; mb = fy_reg; end
                2'd1:    begin ma = item_reg.arm_x; mb = fz_reg; end
                default: begin ma = item_reg.arm_y; mb = fx_reg; end
            endcase
        end
        tprod = ma * mb;
        tdiff = 51'(prt_reg) - 51'(tprod);
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        q_pop      = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = 2'd0;
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = q_item.hit ? ST_MAG1 : ST_LAST;
                end
            end
            ST_MAG1:  state_next = ST_MAG2;
            ST_MAG2:  state_next = ST_SQ;
            ST_SQ:
            begin
                idx_next = (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                if (idx_reg == 2'd2)
                begin
                    state_next = (ssq_sum == '0) ? ST_ACC : ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (bit_reg[0])
                begin
                    state_next = ST_DINIT;
                end
            end
            ST_DINIT: state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == 4'd0)
                begin
                    state_next = ST_FMUL;
                end
            end
            ST_FMUL:
            begin
                idx_next   = (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                state_next = (idx_reg == 2'd2) ? ST_TQA : ST_DINIT;
            end
            ST_TQA:   state_next = ST_TQB;
            ST_TQB:
            begin
                idx_next   = (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                state_next = (idx_reg == 2'd2) ? ST_ACC : ST_TQA;
            end
            ST_ACC:   state_next = ST_LAST;
            ST_LAST:
            begin
                if (!item_reg.last)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= 2'd0;
            cnt_reg       <= 4'd0;
            fsum_x_reg    <= '0;
            fsum_y_reg    <= '0;
            fsum_z_reg    <= '0;
            tsum_x_reg    <= '0;
            tsum_y_reg    <= '0;
            tsum_z_reg    <= '0;
            hits_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (state_reg == ST_DINIT)
            begin
                cnt_reg <= 4'd14;
            end
            else if (state_reg == ST_DIV)
            begin
                cnt_reg <= cnt_reg - 4'd1;
            end
            if (state_reg == ST_ACC)
            begin
                fsum_x_reg <= sat_add(fsum_x_reg, 43'(fx_reg));
                fsum_y_reg <= sat_add(fsum_y_reg, 43'(fy_reg));
                fsum_z_reg <= sat_add(fsum_z_reg, 43'(fz_reg));
                tsum_x_reg <= sat_add(tsum_x_reg, trunc_shr8(tx_reg));
                tsum_y_reg <= sat_add(tsum_y_reg, trunc_shr8(ty_reg));
                tsum_z_reg <= sat_add(tsum_z_reg, trunc_shr8(tz_reg));
                if (hits_reg < HIT_CAP_V)
                begin
                    hits_reg <= hits_reg + 1'b1;
                end
            end
            else if (out_load)
            begin
                fsum_x_reg <= '0;
                fsum_y_reg <= '0;
                fsum_z_reg <= '0;
                tsum_x_reg <= '0;
                tsum_y_reg <= '0;
                tsum_z_reg <= '0;
                hits_reg   <= '0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (totals.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    item_reg <= q_item;
                end
            end
            ST_MAG1:  prod_reg <= 47'(item_reg.depth) * 47'(base_stiffness);
            ST_MAG2:
            begin
                mag_reg <= mag_full[62:30];
                ssq_reg <= '0;
            end
            ST_SQ:
            begin
                ssq_reg <= ssq_sum;
                if (idx_reg == 2'd2)
                begin
                    rad_reg  <= {ssq_sum, 28'b0};
                    root_reg <= '0;
                    bit_reg  <= {2'b01, 60'b0};
                    fx_reg   <= '0;
                    fy_reg   <= '0;
                    fz_reg   <= '0;
                    tx_reg   <= '0;
                    ty_reg   <= '0;
                    tz_reg   <= '0;
                end
            end
            ST_SQRT:
            begin
                if (sq_take)
                begin
                    rad_reg <= rad_reg - trial;
                end
                root_reg <= root_new;
                bit_reg  <= bit_reg >> 2;
                if (bit_reg[0])
                begin
                    len_reg <= root_new[30:0];
                end
            end
            ST_DINIT:
            begin
                rem_reg <= {1'b0, g_mag, 28'b0};
                dsr_reg <= {len_reg, 14'b0};
                quo_reg <= '0;
            end
            ST_DIV:
            begin
                if (div_take)
                begin
                    rem_reg <= rem_reg - dsr_reg;
                end
                quo_reg <= {quo_reg[13:0], div_take};
                dsr_reg <= dsr_reg >> 1;
            end
            ST_FMUL:
            begin
                case (idx_reg)
                    2'd0:    fx_reg <= fval;
                    2'd1:    fy_reg <= fval;
                    default: fz_reg <= fval;
                endcase
            end
            ST_TQA:   prt_reg <= tprod;
            ST_TQB:
            begin
                case (idx_reg)
                    2'd0:    tx_reg <= tdiff;
                    2'd1:    ty_reg <= tdiff;
                    default: tz_reg <= tdiff;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            force_x_reg   <= sat32(fsum_x_reg);
            force_y_reg   <= sat32(fsum_y_reg);
            force_z_reg   <= sat32(fsum_z_reg);
            torque_x_reg  <= sat32(tsum_x_reg);
            torque_y_reg  <= sat32(tsum_y_reg);
            torque_z_reg  <= sat32(tsum_z_reg);
            hit_count_reg <= hits_reg;
            any_hit_reg   <= (hits_reg != '0);
        end
    end

    assign totals.valid     = out_valid_reg;
    assign totals.force_x   = force_x_reg;
    assign totals.force_y   = force_y_reg;
    assign totals.force_z   = force_z_reg;
    assign totals.torque_x  = torque_x_reg;
    assign totals.torque_y  = torque_y_reg;
    assign totals.torque_z  = torque_z_reg;
    assign totals.hit_count = hit_count_reg;
    assign totals.any_hit   = any_hit_reg;

endmodule

@@ rtl/sdf_penalty_force_accumulator.sv @@
// top level of the distance-field penalty force and torque accumulator
//
//   channel   direction  word contents
//   sample    in         lever arm, centre and six neighbour distances, material, last
//   totals    out        saturated force and torque totals, hit count, any hit
//   cfg       in         register index and 16-bit data
//
// a point with no hit skips the back-end arithmetic, a hit with zero gradient skips the
// square root and division; any other hit runs the bit-serial square root and, per
// axis, the 15-step restoring division and force multiply
// after reset the sums are zero, the registers hold their defaults, the queue is empty
// the two-word queue takes samples until full while the back end works; a result word
// left untaken stalls the back end only at the last point of the next frame
module sdf_penalty_force_accumulator #(
    parameter int MAX_POINTS = pfa_pkg::MAX_POINTS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    pfa_sample_if.sink    sample,
    pfa_totals_if.source  totals,
    pfa_cfg_if.sink       cfg
);
    import pfa_pkg::*;

    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_nonempty;
    pfa_item_t   q_in;
    pfa_item_t   q_head;
    logic [15:0] base_stiffness;

    pfa_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample         (sample),
        .cfg            (cfg),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_item         (q_in),
        .base_stiffness (base_stiffness)
    );

    pfa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .nonempty  (q_nonempty),
        .head      (q_head)
    );

    pfa_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_nonempty),
        .q_item         (q_head),
        .q_pop          (q_pop),
        .base_stiffness (base_stiffness),
        .totals         (totals)
    );

endmodule
